// ===== rtl/dhwc_pkg.sv =====
// shared constants and types for the double hash word counter
// no dependencies
package dhwc_pkg;
  localparam int unsigned TABLE_SLOTS = 1024;
  localparam int unsigned SLOT_W = $clog2(TABLE_SLOTS);
  localparam int unsigned CAP_W = 11;
  localparam int unsigned KEY_BYTES = 8;
  localparam int unsigned KEY_W = 64;
  localparam int unsigned CNT_W = 32;
  localparam int unsigned HASH_W = 32;
  localparam int unsigned LEN_W = 4;
  localparam int unsigned ST_W = 3;
  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1021;

  localparam logic [ST_W-1:0] ST_NEW = 3'd0;
  localparam logic [ST_W-1:0] ST_COUNTED = 3'd1;
  localparam logic [ST_W-1:0] ST_HIT = 3'd2;
  localparam logic [ST_W-1:0] ST_ABSENT = 3'd3;
  localparam logic [ST_W-1:0] ST_FULL = 3'd4;

  // remainder request to the serial divider
  typedef struct packed {
    logic              start;
    logic [HASH_W-1:0] dividend;
    logic [CAP_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [CAP_W-1:0] rem;
  } div_rsp_t;
endpackage

// ===== rtl/double_hash_word_counter.sv =====
// Word frequency table, open addressing with double hashing.
// Issue a command by raising start with in_command, in_key_text and in_key_length while
// busy is low; the beat is taken at that edge. in_command 0 inserts or counts the key,
// 1 searches it. The single result appears on out_frequency and out_status for one
// cycle with out_valid high; the receiver cannot stall it and busy stays high until
// that cycle. Hashing takes one key byte per cycle and then launches the divider; two
// serial remainders follow (home slot and step), then each probe reads, compares and
// advances; an update writes back in the compare cycle. The next start can be taken in
// the result cycle. One command at a time.
// The capacity register is written on cfg_valid and cfg_ready; cfg_ready is high
// while the block is idle or clearing. Values below 2 act as 2, above 1024 as 1024.
// After reset a clearing pass writes zero to all 1024 count entries, one per cycle,
// holding busy high until it ends; capacity resets to 1021.
// depends on dhwc_pkg, dhwc_ram, dhwc_rem
module double_hash_word_counter (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_command,
  input  logic [dhwc_pkg::KEY_W-1:0]     in_key_text,
  input  logic [dhwc_pkg::LEN_W-1:0]     in_key_length,
  output logic                           out_valid,
  output logic [dhwc_pkg::CNT_W-1:0]     out_frequency,
  output logic [dhwc_pkg::ST_W-1:0]      out_status,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dhwc_pkg::CAP_W-1:0]     cfg_table_capacity
);
  import dhwc_pkg::*;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_HASH  = 9'b000000100,
    S_HOME  = 9'b000001000,
    S_STEP  = 9'b000010000,
    S_READ  = 9'b000100000,
    S_CHECK = 9'b001000000,
    S_ADV   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CAP_W-1:0]  cap_r, cap_nxt;
  logic [CAP_W-1:0]  ucap_r, ucap_nxt;
  logic              cmd_r, cmd_nxt;
  logic [KEY_W-1:0]  txt_r, txt_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [3:0]        bi_r, bi_nxt;
  logic              stop_r, stop_nxt;
  logic [HASH_W-1:0] hash_r, hash_nxt;
  logic [CAP_W-1:0]  slot_r, slot_nxt;
  logic [CAP_W-1:0]  step_r, step_nxt;
  logic [CAP_W-1:0]  probes_r, probes_nxt;
  logic [SLOT_W-1:0] clr_r, clr_nxt;
  logic              ov_r, ov_nxt;
  logic [CNT_W-1:0]  freq_r, freq_nxt;
  logic [ST_W-1:0]   st_r, st_nxt;

  div_req_t          dreq;
  div_rsp_t          drsp;
  logic              key_we, cnt_we;
  logic [SLOT_W-1:0] ram_addr;
  logic [KEY_W-1:0]  key_rd;
  logic [CNT_W-1:0]  cnt_rd, cnt_wd;
  logic [7:0]        cur_byte;
  logic [CAP_W:0]    slot_sum;
  logic [CNT_W-1:0]  cnt_inc;

  dhwc_rem u_rem (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  dhwc_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_SLOTS)) u_keys (
    .clk(clk), .we(key_we), .addr(ram_addr), .wdata(key_r), .rdata(key_rd));

  dhwc_ram #(.WIDTH(CNT_W), .DEPTH(TABLE_SLOTS)) u_cnts (
    .clk(clk), .we(cnt_we), .addr(ram_addr), .wdata(cnt_wd), .rdata(cnt_rd));

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE) || (state_r == S_CLEAR);
  assign out_valid     = ov_r;
  assign out_frequency = freq_r;
  assign out_status    = st_r;

  assign cur_byte = txt_r[7:0];
  assign slot_sum = {1'b0, slot_r} + {1'b0, step_r};
  assign cnt_inc  = (cnt_rd == '1) ? cnt_rd : cnt_rd + 1'b1;

  always_comb begin
    state_nxt  = state_r;
    cap_nxt    = cap_r;
    ucap_nxt   = ucap_r;
    cmd_nxt    = cmd_r;
    txt_nxt    = txt_r;
    key_nxt    = key_r;
    len_nxt    = len_r;
    bi_nxt     = bi_r;
    stop_nxt   = stop_r;
    hash_nxt   = hash_r;
    slot_nxt   = slot_r;
    step_nxt   = step_r;
    probes_nxt = probes_r;
    clr_nxt    = clr_r;
    ov_nxt     = 1'b0;
    freq_nxt   = freq_r;
    st_nxt     = st_r;
    dreq       = '{start: 1'b0, dividend: hash_r, divisor: ucap_r};
    key_we     = 1'b0;
    cnt_we     = 1'b0;
    cnt_wd     = '0;
    ram_addr   = slot_r[SLOT_W-1:0];
    if (cfg_valid && cfg_ready) begin
      cap_nxt = cfg_table_capacity;
    end
    case (state_r)
      S_CLEAR: begin
        ram_addr = clr_r;
        cnt_we   = 1'b1;
        clr_nxt  = clr_r + 1'b1;
        if (clr_r == SLOT_W'(TABLE_SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_nxt  = in_command;
          txt_nxt  = in_key_text;
          len_nxt  = (in_key_length > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES) : in_key_length;
          key_nxt  = '0;
          hash_nxt = '0;
          bi_nxt   = '0;
          stop_nxt = 1'b0;
          if (cap_r < CAP_W'(2)) begin
            ucap_nxt = CAP_W'(2);
          end else if (cap_r > CAP_W'(TABLE_SLOTS)) begin
            ucap_nxt = CAP_W'(TABLE_SLOTS);
          end else begin
            ucap_nxt = cap_r;
          end
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        // one key byte per cycle; the key ends at its length or a zero byte
        if (bi_r == 4'd8) begin
          dreq.start = 1'b1;
          state_nxt  = S_HOME;
        end else begin
          if (!stop_r && (bi_r < len_r) && (cur_byte != 8'd0)) begin
            hash_nxt = {24'd0, cur_byte} + (hash_r << 5) - hash_r;
            key_nxt  = key_r | ({56'd0, cur_byte} << {bi_r[2:0], 3'b000});
          end else begin
            stop_nxt = 1'b1;
          end
          txt_nxt = txt_r >> 8;
          bi_nxt  = bi_r + 1'b1;
        end
      end
      S_HOME: begin
        if (drsp.done) begin
          slot_nxt      = drsp.rem;
          dreq.start    = 1'b1;
          dreq.divisor  = ucap_r - 1'b1;
          state_nxt     = S_STEP;
        end
      end
      S_STEP: begin
        if (drsp.done) begin
          step_nxt   = drsp.rem + 1'b1;
          probes_nxt = '0;
          state_nxt  = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (cnt_rd == '0) begin
          if (!cmd_r) begin
            key_we   = 1'b1;
            cnt_we   = 1'b1;
            cnt_wd   = CNT_W'(1);
            freq_nxt = CNT_W'(1);
            st_nxt   = ST_NEW;
          end else begin
            freq_nxt = '0;
            st_nxt   = ST_ABSENT;
          end
          state_nxt = S_DONE;
        end else if (key_rd == key_r) begin
          if (!cmd_r) begin
            cnt_we   = 1'b1;
            cnt_wd   = cnt_inc;
            freq_nxt = cnt_inc;
            st_nxt   = ST_COUNTED;
          end else begin
            freq_nxt = cnt_rd;
            st_nxt   = ST_HIT;
          end
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_ADV;
        end
      end
      S_ADV: begin
        probes_nxt = probes_r + 1'b1;
        slot_nxt   = (slot_sum >= {1'b0, ucap_r}) ? CAP_W'(slot_sum - {1'b0, ucap_r})
                                                  : slot_sum[CAP_W-1:0];
        if (probes_r + 1'b1 == ucap_r) begin
          freq_nxt  = '0;
          st_nxt    = cmd_r ? ST_ABSENT : ST_FULL;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_DONE: begin
        ov_nxt    = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cap_r   <= CAP_RESET;
      clr_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cap_r   <= cap_nxt;
      clr_r   <= clr_nxt;
      ov_r    <= ov_nxt;
    end
    ucap_r   <= ucap_nxt;
    cmd_r    <= cmd_nxt;
    txt_r    <= txt_nxt;
    key_r    <= key_nxt;
    len_r    <= len_nxt;
    bi_r     <= bi_nxt;
    stop_r   <= stop_nxt;
    hash_r   <= hash_nxt;
    slot_r   <= slot_nxt;
    step_r   <= step_nxt;
    probes_r <= probes_nxt;
    freq_r   <= freq_nxt;
    st_r     <= st_nxt;
  end

  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (state_r == S_IDLE)) else $error("result beat outside idle");
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> (slot_r < ucap_r)) else $error("probe outside capacity");
  a_new_one: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && st_r == ST_NEW) |-> (freq_r == CNT_W'(1))) else $error("new key count not one");
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && (st_r == ST_ABSENT || st_r == ST_FULL)) |-> (freq_r == '0))
    else $error("miss with nonzero count");
endmodule

// ===== rtl/dhwc_ram.sv =====
// generic single port ram with registered read
// no dependencies
module dhwc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== rtl/dhwc_rem.sv =====
// serial restoring remainder, one quotient bit per cycle
// depends on dhwc_pkg
module dhwc_rem (
  input  logic               clk,
  input  logic               rst_n,
  input  dhwc_pkg::div_req_t req,
  output dhwc_pkg::div_rsp_t rsp
);
  import dhwc_pkg::*;

  localparam int unsigned CNT_BITS = $clog2(HASH_W + 1);

  logic [HASH_W-1:0]   dvd_r, dvd_nxt;
  logic [CAP_W:0]      rem_r, rem_nxt;
  logic [CAP_W-1:0]    dsr_r, dsr_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [CAP_W+1:0]    trial;

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, dvd_r[HASH_W-1]} - {2'b00, dsr_r};
    if (req.start) begin
      dvd_nxt  = req.dividend;
      dsr_nxt  = req.divisor;
      rem_nxt  = '0;
      cnt_nxt  = CNT_BITS'(HASH_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[HASH_W-2:0], 1'b0};
      if (!trial[CAP_W+1]) begin
        rem_nxt = trial[CAP_W:0];
      end else begin
        rem_nxt = {rem_r[CAP_W-1:0], dvd_r[HASH_W-1]};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r[CAP_W-1:0];

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("remainder done held");
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ({1'b0, rem_r} < {2'b00, dsr_r})) else $error("remainder too large");
endmodule

// ===== verif/tb_double_hash_word_counter.sv =====
// testbench for double_hash_word_counter: directed table, then random insert and search beats
// over several table capacities, each result checked against a local copy of the slot table
// depends on dhwc_pkg and the double_hash_word_counter rtl
module tb_double_hash_word_counter;
  import dhwc_pkg::*;

  typedef struct {
    logic              cmd;
    logic [KEY_W-1:0]  text;
    logic [LEN_W-1:0]  len;
    bit                typed;
    logic [CNT_W-1:0]  freq;
    logic [ST_W-1:0]   status;
  } row_t;

  typedef struct {
    logic [CNT_W-1:0] freq;
    logic [ST_W-1:0]  status;
  } word_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic                in_command = 1'b0;
  logic [KEY_W-1:0]    in_key_text = '0;
  logic [LEN_W-1:0]    in_key_length = '0;
  logic                out_valid;
  logic [CNT_W-1:0]    out_frequency;
  logic [ST_W-1:0]     out_status;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CAP_W-1:0]    cfg_table_capacity = '0;

  // local copy of the slot table
  logic [KEY_W-1:0]    word_keys [TABLE_SLOTS];
  logic [CNT_W-1:0]    word_counts [TABLE_SLOTS];
  logic [CAP_W-1:0]    capacity_reg;

  word_result_t        pending_words[$];
  int                  errors = 0;
  int                  beats_sent = 0;
  int                  status_seen [5];
  logic [KEY_W-1:0]    key_pool [48];

  double_hash_word_counter dut (.*);

  always #5 clk = ~clk;

  initial begin
    #200_000_000;
    $display("tb_double_hash_word_counter: errors");
    $finish;
  end

  // expected outcome of one beat, updating the local table
  function automatic word_result_t count_word(logic cmd, logic [KEY_W-1:0] text,
                                              logic [LEN_W-1:0] len);
    word_result_t r;
    logic [KEY_W-1:0] key;
    logic [31:0] h, cap, step, slot, b;
    int n;
    key = '0;
    h = '0;
    n = (len > KEY_BYTES) ? KEY_BYTES : len;
    for (int i = 0; i < n; i++) begin
      b = text[8*i +: 8];
      if (b == 0) break;
      key[8*i +: 8] = b[7:0];
      h = b + 32'd31 * h;
    end
    cap = (capacity_reg < 2) ? 2 : (capacity_reg > TABLE_SLOTS) ? TABLE_SLOTS : capacity_reg;
    step = 1 + h % (cap - 1);
    slot = h % cap;
    r.freq = '0;
    r.status = cmd ? ST_ABSENT : ST_FULL;
    for (int p = 0; p < cap; p++) begin
      if (word_counts[slot] == 0) begin
        if (!cmd) begin
          word_keys[slot] = key;
          word_counts[slot] = 1;
          r.freq = 1;
          r.status = ST_NEW;
        end
        break;
      end
      if (word_keys[slot] == key) begin
        if (cmd) begin
          r.status = ST_HIT;
        end else begin
          if (word_counts[slot] != '1) word_counts[slot] = word_counts[slot] + 1;
          r.status = ST_COUNTED;
        end
        r.freq = word_counts[slot];
        break;
      end
      slot = (slot + step) % cap;
    end
    return r;
  endfunction

  // called at a rising edge; returns at the edge that takes the beat
  task automatic send_word(logic cmd, logic [KEY_W-1:0] text, logic [LEN_W-1:0] len,
                           output word_result_t r);
    int gap;
    gap = $urandom_range(0, 13);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_command <= cmd;
    in_key_text <= text;
    in_key_length <= len;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = count_word(cmd, text, len);
    pending_words.push_back(r);
    beats_sent++;
  endtask

  // write capacity once the block has drained
  task automatic set_capacity(logic [CAP_W-1:0] value);
    start <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_table_capacity <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    capacity_reg = value;
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    word_result_t e;
    if (rst_n && out_valid) begin
      if (pending_words.size() == 0) begin
        $error("result with nothing expected: frequency %0d status %0d",
               out_frequency, out_status);
        errors++;
      end else begin
        e = pending_words.pop_front();
        if (out_frequency !== e.freq) begin
          $error("frequency: expected %0d, got %0d", e.freq, out_frequency);
          errors++;
        end
        if (out_status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_status);
          errors++;
        end
        if (e.status <= ST_FULL) status_seen[e.status]++;
      end
    end
  end

  row_t directed [] = '{
    '{1'b1, 64'h0,                   4'd0,  1'b1, 32'd0, ST_ABSENT},
    '{1'b0, 64'h0,                   4'd0,  1'b1, 32'd1, ST_NEW},
    '{1'b0, 64'hffff_0000,           4'd3,  1'b1, 32'd2, ST_COUNTED},   // empty: zero byte first
    '{1'b1, 64'h0,                   4'd5,  1'b1, 32'd2, ST_HIT},
    '{1'b0, 64'h61,                  4'd1,  1'b1, 32'd1, ST_NEW},
    '{1'b0, 64'hffff_ffff_ffff_ffff, 4'd15, 1'b1, 32'd1, ST_NEW},       // cut to 8 bytes
    '{1'b0, 64'hffff_ffff_ffff_ffff, 4'd8,  1'b1, 32'd2, ST_COUNTED},
    '{1'b1, 64'hffff_ffff_ffff_ffff, 4'd9,  1'b1, 32'd2, ST_HIT},
    '{1'b0, 64'h6600_6261,           4'd4,  1'b1, 32'd1, ST_NEW},       // ends at zero byte
    '{1'b0, 64'h6261,                4'd2,  1'b1, 32'd2, ST_COUNTED},
    '{1'b0, 64'hffff_6261,           4'd2,  1'b1, 32'd3, ST_COUNTED},   // bytes past length
    '{1'b1, 64'h8080_8080_8080_8080, 4'd8,  1'b1, 32'd0, ST_ABSENT},
    '{1'b0, 64'h8080_8080_8080_8080, 4'd8,  1'b0, 32'd0, ST_NEW},
    '{1'b0, 64'h7f01_7f01_7f01_7f01, 4'd7,  1'b0, 32'd0, ST_NEW},
    '{1'b1, 64'h0123_4567_89ab_cdef, 4'd6,  1'b0, 32'd0, ST_NEW}
  };

  logic [CAP_W-1:0] phase_caps [] = '{11'd0, 11'd5, 11'd2047, 11'd17, 11'd1, 11'd64,
                                      11'd1024, 11'd3, 11'd200, 11'd1021};

  initial begin
    word_result_t r;
    logic cmd;
    logic [KEY_W-1:0] text;
    logic [LEN_W-1:0] len;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      word_counts[i] = '0;
      word_keys[i] = '0;
    end
    capacity_reg = CAP_RESET;
    for (int i = 0; i < 48; i++) key_pool[i] = {$urandom, $urandom};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      send_word(directed[i].cmd, directed[i].text, directed[i].len, r);
      if (directed[i].typed && (r.freq !== directed[i].freq ||
                                r.status !== directed[i].status)) begin
        $error("row %0d: table says %0d/%0d, predictor %0d/%0d", i, directed[i].freq,
               directed[i].status, r.freq, r.status);
        errors++;
      end
    end

    // capacity 2: slot 0 still holds the empty key, so the later of these keys find both slots taken
    set_capacity(11'd2);
    send_word(1'b0, 64'h7a7a, 4'd2, r);
    send_word(1'b0, 64'h7979, 4'd2, r);
    send_word(1'b0, 64'h7878, 4'd2, r);
    send_word(1'b1, 64'h7777, 4'd2, r);

    foreach (phase_caps[p]) begin
      set_capacity(phase_caps[p]);
      repeat (162) begin
        cmd = ($urandom_range(0, 2) == 0);
        if ($urandom_range(0, 3) != 0) begin
          text = key_pool[$urandom_range(0, 47)];
          len = $urandom_range(0, 8);
        end else begin
          text = {$urandom, $urandom};
          len = $urandom_range(0, 15);
        end
        send_word(cmd, text, len, r);
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("%0d beats over %0d capacities: new %0d, counted %0d, hit %0d, absent %0d,",
             beats_sent, phase_caps.size() + 2, status_seen[0], status_seen[1],
             status_seen[2], status_seen[3]);
    $display("table full %0d", status_seen[4]);
    if (errors == 0) begin
      $display("tb_double_hash_word_counter: clean");
    end else begin
      $display("tb_double_hash_word_counter: errors");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/dhwc_pkg.sv
rtl/dhwc_ram.sv
rtl/dhwc_rem.sv
rtl/double_hash_word_counter.sv
verif/tb_double_hash_word_counter.sv
